// File: hdl/dhke_pkg.sv
// shared types and constants for the diffie-hellman key exchange block
package dhke_pkg;

  // width of every payload and register field
  localparam int FIELD_BITS = 32;

  // default arithmetic word width
  localparam int WORD_BITS_DEF = 32;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GENERATOR = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS   = 2'd1;

  // register reset values
  localparam logic [FIELD_BITS-1:0] GENERATOR_RST = 32'd5;
  localparam logic [FIELD_BITS-1:0] MODULUS_RST   = 32'd23;

  typedef struct packed {
    logic [FIELD_BITS-1:0] first_secret;
    logic [FIELD_BITS-1:0] second_secret;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] first_public_key;
    logic [FIELD_BITS-1:0] second_public_key;
    logic [FIELD_BITS-1:0] shared_secret;
  } out_item_t;

endpackage

// File: hdl/diffie_hellman_key_exchange.sv
// diffie-hellman key exchange: three bit-serial modular exponentiations per item
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+-----------------------------------
//   input    | start, busy, in_item          | taken when start high, busy low
//   result   | out_valid, out_item           | one-cycle strobe, cannot be held
//   config   | cfg_we, cfg_index, cfg_data   | written when cfg_we high
//
// one item at a time: the generator is first reduced bit by bit, then each of
// the three powers runs W square steps plus one multiply step per set exponent
// bit, and each modular multiply runs a doubling step per multiplier bit plus an
// add step per set bit on the shared add/compare/subtract unit (W = WORD_BITS).
// a zero modulus gives an all-zero result in the cycle after the item is taken.
// reset is synchronous, active low, and restores generator 5 and modulus 23.
// the result strobe is never stalled; busy stays high until the result is shown.
module diffie_hellman_key_exchange #(
  parameter int WORD_BITS = dhke_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  dhke_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  output dhke_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [dhke_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [dhke_pkg::FIELD_BITS-1:0]      cfg_data
);

  localparam int W  = WORD_BITS;
  localparam int FB = dhke_pkg::FIELD_BITS;
  localparam int CW = $clog2(WORD_BITS + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RED  = 2'd1;
  localparam logic [1:0] ST_DBL  = 2'd2;
  localparam logic [1:0] ST_ADD  = 2'd3;

  // which exponentiation is running
  localparam logic [1:0] POW_A   = 2'd0;
  localparam logic [1:0] POW_B   = 2'd1;
  localparam logic [1:0] POW_KEY = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [1:0]            pow_r, pow_nxt;
  logic                  sq_r, sq_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FB-1:0]         generator_r, modulus_r;
  logic [W-1:0]          m_r, m_nxt;
  logic [W-1:0]          sa_r, sa_nxt;
  logic [W-1:0]          sb_r, sb_nxt;
  logic [W-1:0]          gred_r, gred_nxt;
  logic [W-1:0]          pa_r, pa_nxt;
  logic [W-1:0]          pb_r, pb_nxt;
  logic [W-1:0]          exp_r, exp_nxt;
  logic [CW-1:0]         ecnt_r, ecnt_nxt;
  logic [W-1:0]          mm_x_r, mm_x_nxt;
  logic [W-1:0]          mm_y_r, mm_y_nxt;
  logic [W-1:0]          mm_acc_r, mm_acc_nxt;
  logic [CW-1:0]         bcnt_r, bcnt_nxt;
  dhke_pkg::out_item_t   out_item_r, out_item_nxt;

  logic [W-1:0]          one_w;
  logic [W-1:0]          base_sel;
  logic [W-1:0]          add_b;
  logic [W:0]            am_sum;
  logic [W-1:0]          am_res;
  logic [W:0]            rd_sum;
  logic [W-1:0]          rd_res;
  logic [W-1:0]          start_m;
  logic                  mm_last;
  logic                  ex_last;

  // shared modular add: acc + acc or acc + x, one conditional subtract
  assign add_b  = (state_r == ST_ADD) ? mm_x_r : mm_acc_r;
  assign am_sum = {1'b0, mm_acc_r} + {1'b0, add_b};
  assign am_res = (am_sum >= {1'b0, m_r}) ? W'(am_sum - {1'b0, m_r}) : am_sum[W-1:0];

  // generator reduction: shift in one bit, subtract once
  assign rd_sum = {mm_acc_r, mm_y_r[W-1]};
  assign rd_res = (rd_sum >= {1'b0, m_r}) ? W'(rd_sum - {1'b0, m_r}) : rd_sum[W-1:0];

  assign one_w    = (m_r == W'(1)) ? '0 : W'(1);
  assign base_sel = (pow_r == POW_KEY) ? pa_r : gred_r;
  assign mm_last  = (bcnt_r == CW'(1));
  assign ex_last  = (ecnt_r == CW'(1));
  assign start_m  = W'(modulus_r);

  // sequencer
  always_comb begin
    logic          bit_done;
    logic          mul_done;
    logic          exp_adv;
    logic          pow_done;
    logic          sq_one;
    logic [W-1:0]  v;

    state_nxt     = state_r;
    pow_nxt       = pow_r;
    sq_nxt        = sq_r;
    out_valid_nxt = 1'b0;
    m_nxt         = m_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    gred_nxt      = gred_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    exp_nxt       = exp_r;
    ecnt_nxt      = ecnt_r;
    mm_x_nxt      = mm_x_r;
    mm_y_nxt      = mm_y_r;
    mm_acc_nxt    = mm_acc_r;
    bcnt_nxt      = bcnt_r;
    out_item_nxt  = out_item_r;
    bit_done      = 1'b0;
    mul_done      = 1'b0;
    exp_adv       = 1'b0;
    pow_done      = 1'b0;
    sq_one        = 1'b0;
    v             = am_res;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          sa_nxt = W'(in_item.first_secret);
          sb_nxt = W'(in_item.second_secret);
          m_nxt  = start_m;
          if (start_m == '0) begin
            // zero modulus: all-zero result right away
            out_item_nxt  = '0;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt  = ST_RED;
            mm_acc_nxt = '0;
            mm_y_nxt   = W'(generator_r);
            bcnt_nxt   = CW'(W);
          end
        end
      end
      ST_RED: begin
        mm_acc_nxt = rd_res;
        mm_y_nxt   = mm_y_r << 1;
        bcnt_nxt   = bcnt_r - CW'(1);
        if (mm_last) begin
          gred_nxt = rd_res;
          pow_nxt  = POW_A;
          exp_nxt  = sa_r;
          ecnt_nxt = CW'(W);
          sq_one   = 1'b1;
        end
      end
      ST_DBL: begin
        mm_acc_nxt = am_res;
        if (mm_y_r[W-1]) begin
          state_nxt = ST_ADD;
        end else begin
          bit_done = 1'b1;
        end
      end
      ST_ADD: begin
        mm_acc_nxt = am_res;
        bit_done   = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // next multiplier bit
    if (bit_done) begin
      state_nxt = ST_DBL;
      mm_y_nxt  = mm_y_r << 1;
      bcnt_nxt  = bcnt_r - CW'(1);
      mul_done  = mm_last;
    end

    // end of one modular multiply
    if (mul_done) begin
      if (sq_r && exp_r[W-1]) begin
        mm_x_nxt   = base_sel;
        mm_y_nxt   = am_res;
        mm_acc_nxt = '0;
        bcnt_nxt   = CW'(W);
        sq_nxt     = 1'b0;
      end else begin
        exp_adv = 1'b1;
      end
    end

    // next exponent bit, or end of the power
    if (exp_adv) begin
      exp_nxt  = exp_r << 1;
      ecnt_nxt = ecnt_r - CW'(1);
      if (ex_last) begin
        pow_done = 1'b1;
      end else begin
        mm_x_nxt   = am_res;
        mm_y_nxt   = am_res;
        mm_acc_nxt = '0;
        bcnt_nxt   = CW'(W);
        sq_nxt     = 1'b1;
      end
    end

    // hand over to the next power or show the result
    if (pow_done) begin
      case (pow_r)
        POW_A: begin
          pa_nxt   = v;
          pow_nxt  = POW_B;
          exp_nxt  = sb_r;
          ecnt_nxt = CW'(W);
          sq_one   = 1'b1;
        end
        POW_B: begin
          pb_nxt   = v;
          pow_nxt  = POW_KEY;
          exp_nxt  = sb_r;
          ecnt_nxt = CW'(W);
          sq_one   = 1'b1;
        end
        default: begin
          out_item_nxt.first_public_key  = FB'(pa_r);
          out_item_nxt.second_public_key = FB'(pb_r);
          out_item_nxt.shared_secret     = FB'(v);
          out_valid_nxt                  = 1'b1;
          state_nxt                      = ST_IDLE;
        end
      endcase
    end

    // first square of a power starts from one mod m
    if (sq_one) begin
      state_nxt  = ST_DBL;
      mm_x_nxt   = one_w;
      mm_y_nxt   = one_w;
      mm_acc_nxt = '0;
      bcnt_nxt   = CW'(W);
      sq_nxt     = 1'b1;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pow_r       <= POW_A;
      sq_r        <= 1'b0;
      out_valid_r <= 1'b0;
      generator_r <= dhke_pkg::GENERATOR_RST;
      modulus_r   <= dhke_pkg::MODULUS_RST;
    end else begin
      state_r     <= state_nxt;
      pow_r       <= pow_nxt;
      sq_r        <= sq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          dhke_pkg::REG_GENERATOR: generator_r <= cfg_data;
          dhke_pkg::REG_MODULUS:   modulus_r   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    gred_r     <= gred_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    exp_r      <= exp_nxt;
    ecnt_r     <= ecnt_nxt;
    mm_x_r     <= mm_x_nxt;
    mm_y_r     <= mm_y_nxt;
    mm_acc_r   <= mm_acc_nxt;
    bcnt_r     <= bcnt_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a result only follows an accepted item or running work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(start || busy))
    else $error("result strobe without an item in flight");

  // the add step only follows a doubling step on a set multiplier bit
  a_add_after_dbl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) |-> ($past(state_r) == ST_DBL && $past(mm_y_r[W-1])))
    else $error("modular add step out of order");

  // the partial product stays a residue
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DBL || state_r == ST_ADD || state_r == ST_RED) |-> (mm_acc_r < m_r))
    else $error("partial product not reduced");

  // work never runs with a zero modulus
  a_mod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (m_r != '0))
    else $error("busy with zero modulus");

  // a result is shown only once the block is idle again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result strobe while still busy");

endmodule
